@@ src/hamming_packet_decoder_macros.svh @@
// assertion macros for the hamming packet decoder
`ifndef HAMMING_PACKET_DECODER_MACROS_SVH
`define HAMMING_PACKET_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HPD_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HPD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ src/hpd_pkg.sv @@
// types, constants and tables shared by the hamming packet decoder
package hpd_pkg;

  // check rows, row r gives syndrome bit (3-r)
  localparam logic [15:0] CHECK_ROW_0 = 16'b0100110101111000;
  localparam logic [15:0] CHECK_ROW_1 = 16'b0110101111000100;
  localparam logic [15:0] CHECK_ROW_2 = 16'b0011010111100010;
  localparam logic [15:0] CHECK_ROW_3 = 16'b0001101011110001;

  localparam int unsigned START_BIT   = 10;
  localparam logic [10:0] START_MASK  = 11'h400;
  localparam logic [6:0]  ID_MASK     = 7'h7F;
  localparam logic [10:0] PAY_HI_MASK = 11'h3FF;
  localparam logic [7:0]  DEST_MASK   = 8'hFC;

  localparam logic [2:0] LAST_INDEX = 3'd4;

  typedef struct packed {
    logic [14:0] codeword;
    logic        message_start;
  } word_item_t;

  typedef struct packed {
    logic [6:0]  message_id;
    logic [5:0]  source_address;
    logic [5:0]  destination_address;
    logic [2:0]  message_type;
    logic [31:0] payload;
    logic [3:0]  error_count;
  } msg_item_t;

  // corrected word as handed from the corrector to the assembler
  typedef struct packed {
    logic [10:0] data;
    logic        bad;
  } hpd_corr_t;

  // single-bit error pattern for each syndrome
  function automatic logic [15:0] flip_pattern(input logic [3:0] syn);
    logic [15:0] p;
    case (syn)
      4'd0:    p = 16'h0000;
      4'd1:    p = 16'h0001;
      4'd2:    p = 16'h0002;
      4'd3:    p = 16'h1000;
      4'd4:    p = 16'h0004;
      4'd5:    p = 16'h0200;
      4'd6:    p = 16'h2000;
      4'd7:    p = 16'h0080;
      4'd8:    p = 16'h0008;
      4'd9:    p = 16'h0010;
      4'd10:   p = 16'h0400;
      4'd11:   p = 16'h0020;
      4'd12:   p = 16'h4000;
      4'd13:   p = 16'h0800;
      4'd14:   p = 16'h0100;
      4'd15:   p = 16'h0040;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

@@ src/hpd_corrector.sv @@
// syndrome computation and single-bit correction of one codeword
module hpd_corrector (
  input  logic [14:0]       codeword,
  output hpd_pkg::hpd_corr_t corr
);

  logic [15:0] word_ext;
  logic [3:0]  syn;
  logic [15:0] fixed;

  assign word_ext = {1'b0, codeword};

  assign syn[3] = ^(word_ext & hpd_pkg::CHECK_ROW_0);
  assign syn[2] = ^(word_ext & hpd_pkg::CHECK_ROW_1);
  assign syn[1] = ^(word_ext & hpd_pkg::CHECK_ROW_2);
  assign syn[0] = ^(word_ext & hpd_pkg::CHECK_ROW_3);

  assign fixed = word_ext ^ hpd_pkg::flip_pattern(syn);

  assign corr.data = fixed[14:4];
  assign corr.bad  = (syn != 4'd0);

endmodule

@@ src/hpd_assembler.sv @@
// message state: word position, held data words, running error count
module hpd_assembler (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic                message_start,
  input  hpd_pkg::hpd_corr_t  corr,
  output logic                emit,
  output hpd_pkg::msg_item_t  result
);

  logic [2:0]  word_index;
  logic [2:0]  running_errors;
  logic [10:0] held [4];

  logic        restart;
  logic [2:0]  idx;
  logic [2:0]  run_eff;
  logic [5:0]  src_now;
  logic        err_start;
  logic        err_id;
  logic        err_src;
  logic [3:0]  errs;
  logic [10:0] pay_hi;
  logic [7:0]  w1_low;

  // a start mark always makes this word 0
  assign restart = message_start || (word_index > hpd_pkg::LAST_INDEX);
  assign idx     = restart ? 3'd0 : word_index;
  assign run_eff = restart ? 3'd0 : running_errors;

  assign src_now   = {held[0][2:0], corr.data[10:8]};
  assign err_start = (idx == 3'd0) && ((corr.data & hpd_pkg::START_MASK) == 11'd0);
  assign err_id    = (idx == 3'd0) && ((corr.data[9:3] & hpd_pkg::ID_MASK) == 7'd0);
  assign err_src   = (idx == 3'd1) && (src_now == 6'd0);

  assign errs = {1'b0, run_eff} + {3'b0, corr.bad} + {3'b0, err_start}
              + {3'b0, err_id} + {3'b0, err_src};

  assign emit = (idx == hpd_pkg::LAST_INDEX);

  assign pay_hi = held[2] & hpd_pkg::PAY_HI_MASK;
  assign w1_low = held[1][7:0] & hpd_pkg::DEST_MASK;

  assign result.message_id          = held[0][9:3] & hpd_pkg::ID_MASK;
  assign result.source_address      = {held[0][2:0], held[1][10:8]};
  assign result.destination_address = w1_low[7:2];
  assign result.message_type        = {held[1][1:0], held[2][hpd_pkg::START_BIT]};
  assign result.payload             = {pay_hi[9:0], held[3], corr.data};
  assign result.error_count         = errs;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index     <= 3'd0;
      running_errors <= 3'd0;
    end else if (go) begin
      if (emit) begin
        word_index     <= 3'd0;
        running_errors <= 3'd0;
      end else begin
        word_index     <= idx + 3'd1;
        running_errors <= errs[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !emit) begin
      held[idx[1:0]] <= corr.data;
    end
  end

endmodule

@@ src/hamming_packet_decoder.sv @@
// top level of the hamming packet decoder: input register, decode, result register
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   word    | word_valid / word_ready   | hpd_pkg::word_item_t, one codeword
//   msg     | msg_valid  / msg_ready    | hpd_pkg::msg_item_t, one message
//
// one codeword per cycle sustained while the result register is free to take a message;
// msg_valid is set from the fifth word through the input register and the result register
// rst is synchronous and clears the word position, error count and both valids
// a stalled result holds only the fifth word of the next message in the input
// register; words 0..3 keep flowing while the result waits
`include "hamming_packet_decoder_macros.svh"

module hamming_packet_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                word_valid,
  output logic                word_ready,
  input  hpd_pkg::word_item_t word,
  output logic                msg_valid,
  input  logic                msg_ready,
  output hpd_pkg::msg_item_t  msg
);

  logic                s1_valid;
  hpd_pkg::word_item_t s1_item;

  hpd_pkg::hpd_corr_t  corr;
  hpd_pkg::msg_item_t  result;
  logic                emit;
  logic                out_free;
  logic                s1_go;

  assign out_free   = !msg_valid || msg_ready;
  assign s1_go      = s1_valid && (!emit || out_free);
  assign word_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (word_ready) begin
      s1_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      s1_item <= word;
    end
  end

  hpd_corrector u_corrector (
    .codeword (s1_item.codeword),
    .corr     (corr)
  );

  hpd_assembler u_assembler (
    .clk           (clk),
    .rst           (rst),
    .go            (s1_go),
    .message_start (s1_item.message_start),
    .corr          (corr),
    .emit          (emit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (out_free) begin
      msg_valid <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      msg <= result;
    end
  end

  `HPD_ASSERT_NOW(a_err_range, clk, rst, msg_valid, msg.error_count <= 4'd8, "error count above 8")
  `HPD_ASSERT_NEXT(a_emit_lands, clk, rst, s1_go && emit, msg_valid, "message not registered")
  `HPD_ASSERT_NEXT(a_last_waits, clk, rst, s1_valid && emit && !out_free, s1_valid, "last word lost")

endmodule

@@ test/hamming_packet_decoder_tb.sv @@
// testbench for hamming_packet_decoder: random and directed codeword messages against a predictor
module hamming_packet_decoder_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 530;

  // bit flip applied for each syndrome value
  localparam logic [15:0] FIX_PATTERN [16] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h1000,
    16'h0004, 16'h0200, 16'h2000, 16'h0080,
    16'h0008, 16'h0010, 16'h0400, 16'h0020,
    16'h4000, 16'h0800, 16'h0100, 16'h0040
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                word_valid = 1'b0;
  logic                word_ready;
  hpd_pkg::word_item_t word = '0;
  logic                msg_valid;
  logic                msg_ready = 1'b0;
  hpd_pkg::msg_item_t  msg;

  hamming_packet_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .msg        (msg)
  );

  always #4 clk = ~clk;

  hpd_pkg::word_item_t word_q[$];
  hpd_pkg::msg_item_t  expected_msgs[$];
  int         words_queued = 0;
  int         fail_count = 0;
  int         send_idle_pct = 33;
  int         recv_idle_pct = 60;
  int         long_hold = 0;
  int         quiet_cycles = 0;

  // decoder state as predicted
  logic [2:0]  word_pos = '0;
  logic [10:0] held_data [4];
  logic [2:0]  run_errs = '0;

  function automatic logic [3:0] syndrome_of(input logic [14:0] cw);
    logic [3:0] syn;
    syn[3] = ^(hpd_pkg::CHECK_ROW_0 & {1'b0, cw});
    syn[2] = ^(hpd_pkg::CHECK_ROW_1 & {1'b0, cw});
    syn[1] = ^(hpd_pkg::CHECK_ROW_2 & {1'b0, cw});
    syn[0] = ^(hpd_pkg::CHECK_ROW_3 & {1'b0, cw});
    return syn;
  endfunction

  // check bit (3-r) only appears in row r, so the checks equal the data-only syndrome
  function automatic logic [14:0] encode(input logic [10:0] data);
    return {data, syndrome_of({data, 4'b0000})};
  endfunction

  function automatic logic [14:0] hit_bits(input logic [14:0] cw, input int n);
    logic [14:0] mask;
    int p;
    mask = '0;
    for (int k = 0; k < n; k++) begin
      do p = $urandom_range(14, 0); while (mask[p]);
      mask[p] = 1'b1;
    end
    return cw ^ mask;
  endfunction

  task automatic decode_codeword(input hpd_pkg::word_item_t w);
    logic [3:0]  syn;
    logic [14:0] fixed;
    logic [10:0] data;
    logic [3:0]  errs;
    hpd_pkg::msg_item_t m;
    if (w.message_start || word_pos > hpd_pkg::LAST_INDEX) begin
      word_pos = '0;
      run_errs = '0;
    end
    syn   = syndrome_of(w.codeword);
    fixed = w.codeword ^ FIX_PATTERN[syn][14:0];
    data  = fixed[14:4];
    errs  = {1'b0, run_errs} + (syn != 4'd0);
    if (word_pos == 3'd0) begin
      if (!data[10]) errs++;
      if (data[9:3] == 7'd0) errs++;
    end else if (word_pos == 3'd1) begin
      if ({held_data[0][2:0], data[10:8]} == 6'd0) errs++;
    end
    if (word_pos < hpd_pkg::LAST_INDEX) begin
      held_data[word_pos[1:0]] = data;
      run_errs = errs[2:0];
      word_pos++;
    end else begin
      m.message_id          = held_data[0][9:3];
      m.source_address      = {held_data[0][2:0], held_data[1][10:8]};
      m.destination_address = held_data[1][7:2];
      m.message_type        = {held_data[1][1:0], held_data[2][10]};
      m.payload             = {held_data[2][9:0], held_data[3], data};
      m.error_count         = errs;
      expected_msgs.push_back(m);
      word_pos = '0;
      run_errs = '0;
    end
  endtask

  // flips holds two bits per word: how many bits of that word get corrupted
  task automatic queue_message(input logic mark, input logic [6:0] id, input logic [5:0] src,
                               input logic [5:0] dst, input logic [2:0] typ,
                               input logic [31:0] pay, input logic start_bit,
                               input int n_words, input logic [9:0] flips);
    logic [10:0] dw [5];
    hpd_pkg::word_item_t it;
    dw[0] = {start_bit, id, src[5:3]};
    dw[1] = {src[2:0], dst, typ[2:1]};
    dw[2] = {typ[0], pay[31:22]};
    dw[3] = pay[21:11];
    dw[4] = pay[10:0];
    for (int k = 0; k < n_words; k++) begin
      it.codeword      = hit_bits(encode(dw[k]), flips[2*k +: 2]);
      it.message_start = (k == 0) ? mark : 1'b0;
      word_q.push_back(it);
      words_queued++;
    end
  endtask

  task automatic queue_random(input int target);
    logic [9:0] flips;
    hpd_pkg::word_item_t it;
    int         r;
    while (words_queued < target) begin
      r = $urandom_range(99, 0);
      if (r < 5) begin
        // stray word
        it.codeword      = 15'($urandom_range(32767, 0));
        it.message_start = 1'($urandom_range(1, 0));
        word_q.push_back(it);
        words_queued++;
      end else begin
        for (int k = 0; k < 5; k++) begin
          r = $urandom_range(99, 0);
          flips[2*k +: 2] = (r < 60) ? 2'd0 : (r < 85) ? 2'd1 : (r < 95) ? 2'd2 : 2'd3;
        end
        queue_message($urandom_range(99, 0) < 90,
                      ($urandom_range(9, 0) == 0) ? 7'd0 : 7'($urandom),
                      ($urandom_range(9, 0) == 0) ? 6'd0 : 6'($urandom),
                      6'($urandom), 3'($urandom), $urandom,
                      $urandom_range(9, 0) != 0,
                      ($urandom_range(9, 0) == 0) ? $urandom_range(4, 1) : 5,
                      flips);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!word_valid || word_ready) begin
      if (word_valid) decode_codeword(word);
      if (word_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        word       <= word_q.pop_front();
        word_valid <= 1'b1;
      end else begin
        word_valid <= 1'b0;
      end
    end
  end

  task automatic check_msg(input hpd_pkg::msg_item_t got);
    hpd_pkg::msg_item_t want;
    if (expected_msgs.size() == 0) begin
      $error("msg item with no message pending: %h", got);
      fail_count++;
    end else begin
      want = expected_msgs.pop_front();
      if (got.message_id !== want.message_id) begin
        $error("message_id: expected %0h, got %0h", want.message_id, got.message_id);
        fail_count++;
      end
      if (got.source_address !== want.source_address) begin
        $error("source_address: expected %0h, got %0h", want.source_address,
               got.source_address);
        fail_count++;
      end
      if (got.destination_address !== want.destination_address) begin
        $error("destination_address: expected %0h, got %0h", want.destination_address,
               got.destination_address);
        fail_count++;
      end
      if (got.message_type !== want.message_type) begin
        $error("message_type: expected %0h, got %0h", want.message_type, got.message_type);
        fail_count++;
      end
      if (got.payload !== want.payload) begin
        $error("payload: expected %0h, got %0h", want.payload, got.payload);
        fail_count++;
      end
      if (got.error_count !== want.error_count) begin
        $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
        fail_count++;
      end
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      msg_ready <= 1'b0;
    end else begin
      if (msg_valid && msg_ready) check_msg(msg);
      if (long_hold > 0) begin
        long_hold = long_hold - 1;
        msg_ready <= 1'b0;
      end else begin
        msg_ready <= $urandom_range(99, 0) >= recv_idle_pct;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((word_valid && word_ready) || (msg_valid && msg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // all-ones fields, clean
    queue_message(1'b1, 7'h7F, 6'h3F, 6'h3F, 3'h7, 32'hFFFF_FFFF, 1'b1, 5, 10'd0);
    // all-zero codewords: start bit, id and source all missing
    queue_message(1'b1, 7'h00, 6'h00, 6'h00, 3'h0, 32'h0, 1'b0, 5, 10'd0);
    // start mark mid-message drops the partial one; single error in every word
    queue_message(1'b1, 7'h15, 6'h2A, 6'h11, 3'h5, 32'h1234_5678, 1'b1, 3, 10'd0);
    queue_message(1'b1, 7'h6B, 6'h05, 6'h30, 3'h2, 32'hA5A5_0F0F, 1'b1, 5, 10'b0101010101);
    // no start mark at position 0, double errors in words 0 and 2, single error in word 4
    queue_message(1'b0, 7'h01, 6'h20, 6'h01, 3'h4, 32'h8000_0001, 1'b1, 5, 10'b0100100010);
    word_q.push_back('{codeword: 15'h7FFF, message_start: 1'b1});
    words_queued++;
    queue_random(PHASE_ITEMS);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (word_q.size() != 0) @(posedge clk);
    @(negedge clk);
    send_idle_pct = 60;
    recv_idle_pct = 33;
    queue_random(2 * PHASE_ITEMS);

    while (word_q.size() != 0) @(posedge clk);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold = 300;
    queue_random(3 * PHASE_ITEMS);

    while (word_q.size() != 0 || word_valid) @(posedge clk);
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/hpd_pkg.sv
src/hpd_corrector.sv
src/hpd_assembler.sv
src/hamming_packet_decoder.sv
test/hamming_packet_decoder_tb.sv
